// File: sv/assert_macros.svh
// assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion, switched off while reset is high
`define ATM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent assertion that also holds across reset cycles
`define ATM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/atm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atm_pkg
// types, sizes and helpers of the 3x3 alpha-trimmed mean filter
// ----------------------------------------------------------------------------
package atm_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int PIXEL_BITS = 8;

   // configuration port
   localparam int CFG_BITS     = 11;
   localparam int CSR_IDX_BITS = 2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_WIDTH  = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_HEIGHT = CSR_IDX_BITS'(1);
   localparam int WIDTH_RESET  = 1024;
   localparam int HEIGHT_RESET = 1024;

   // position and dimension widths
   localparam int DIM_MAX  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int DIM_BITS = $clog2(DIM_MAX + 1);
   localparam int COL_BITS = $clog2(MAX_WIDTH);
   localparam int ROW_BITS = $clog2(MAX_HEIGHT + 2);
   localparam int CMP_BITS = ((DIM_BITS > ROW_BITS) ? DIM_BITS : ROW_BITS) + 1;

   // window and averaging
   localparam int WIN_SIDE   = 3;
   localparam int WIN_CELLS  = WIN_SIDE * WIN_SIDE;
   localparam int KEEP_COUNT = WIN_SIDE * WIN_SIDE - 2;
   localparam int ROUND_BIAS = KEEP_COUNT / 2;
   localparam int SUM_BITS   = PIXEL_BITS + 4;
   localparam int DIV_SHIFT  = SUM_BITS + 3;
   localparam int PROD_BITS  = SUM_BITS + DIV_SHIFT;
   localparam int RECIP      = (2 ** DIV_SHIFT + KEEP_COUNT - 1) / KEEP_COUNT;

   // queue between front and back
   localparam int QDEPTH    = 4;
   localparam int QPTR_BITS = $clog2(QDEPTH);
   localparam int QCNT_BITS = $clog2(QDEPTH + 1);

   typedef logic [PIXEL_BITS-1:0] atm_pix_type;

   typedef struct packed {
      atm_pix_type pixel;
      logic        padding;
   } atm_req_type;

   typedef struct packed {
      atm_pix_type filtered;
      logic        frame_end;
   } atm_rsp_type;

   typedef struct packed {
      atm_pix_type [WIN_CELLS-1:0] cells;
      logic                        last;
   } atm_win_type;

   typedef struct packed {
      logic                 head_valid;
      logic [QCNT_BITS-1:0] level;
   } atm_qstat_type;

   // zero acts as one, anything above the limit acts as the limit
   function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [CFG_BITS-1:0] value,
                                                     input int unsigned limit);
      logic [DIM_BITS-1:0] result;
      if (value == '0) begin
         result = DIM_BITS'(1);
      end else if (32'(value) > limit) begin
         result = DIM_BITS'(limit);
      end else begin
         result = DIM_BITS'(value);
      end
      return result;
   endfunction

endpackage

// File: sv/atm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atm_front
// raster position, line stores, window and edge masking of each request
// ----------------------------------------------------------------------------
module atm_front import atm_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  atm_req_type             req_data,
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]     csr_wr_data,
   input  atm_qstat_type           qstat,
   output logic                    push_valid,
   output atm_win_type             push_data
);

   typedef logic [2*PIXEL_BITS-1:0] pair_type;

   typedef struct packed {
      logic up_ok;
      logic dn_ok;
      logic left_ok;
      logic right_ok;
   } bound_mask_type;

   // line stores: upper half holds the older row
   pair_type line_mem_ff [MAX_WIDTH];
   pair_type rd_ff;

   logic [DIM_BITS-1:0] wid_ff, wid_in;
   logic [DIM_BITS-1:0] hgt_ff, hgt_in;
   logic [COL_BITS-1:0] col_ff, col_in;
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic                s1_valid_ff, s1_valid_in;

   logic                s1_emit_ff, s1_emit_in;
   logic                s1_last_ff, s1_last_in;
   atm_pix_type         s1_pix_ff, s1_pix_in;
   logic [COL_BITS-1:0] s1_col_ff, s1_col_in;
   bound_mask_type      s1_mask_ff, s1_mask_in;
   logic                fwd_hit_ff, fwd_hit_in;
   pair_type            fwd_data_ff, fwd_data_in;
   atm_pix_type         win_ff [WIN_CELLS];
   atm_pix_type         win_in [WIN_CELLS];

   logic                accept;
   logic [CMP_BITS-1:0] col_ext, row_ext, w_ext, h_ext;
   logic                col_wrap;
   logic                emit, last;
   bound_mask_type      mask;
   atm_pix_type         pix_v;
   pair_type            pair, wr_pair;
   logic                cfg_hit;

   assign req_stall = ((QCNT_BITS + 1)'(qstat.level)
                       + (QCNT_BITS + 1)'(s1_valid_ff & s1_emit_ff))
                      >= (QCNT_BITS + 1)'(QDEPTH);
   assign accept    = req_valid && !req_stall;

   // classify the incoming tick
   always_comb begin
      col_ext = CMP_BITS'(col_ff);
      row_ext = CMP_BITS'(row_ff);
      w_ext   = CMP_BITS'(wid_ff);
      h_ext   = CMP_BITS'(hgt_ff);
      pix_v   = (req_data.padding || (row_ext >= h_ext)) ? '0 : req_data.pixel;
      if (col_ff != '0) begin
         // centre is one row up, one column left
         emit          = (row_ext >= CMP_BITS'(1)) && (row_ext <= h_ext);
         mask.up_ok    = row_ext >= CMP_BITS'(2);
         mask.dn_ok    = row_ext < h_ext;
         mask.left_ok  = col_ext >= CMP_BITS'(2);
         mask.right_ok = 1'b1;
         last          = 1'b0;
      end else begin
         // centre is the last column two rows up
         emit          = (row_ext >= CMP_BITS'(2)) && (row_ext <= h_ext + CMP_BITS'(1));
         mask.up_ok    = row_ext >= CMP_BITS'(3);
         mask.dn_ok    = row_ext <= h_ext;
         mask.left_ok  = w_ext >= CMP_BITS'(2);
         mask.right_ok = 1'b0;
         last          = row_ext == h_ext + CMP_BITS'(1);
      end
      col_wrap = (col_ext + CMP_BITS'(1)) >= w_ext;
   end

   // configuration and raster position
   always_comb begin
      wid_in  = wid_ff;
      hgt_in  = hgt_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      cfg_hit = 1'b0;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: begin
               wid_in  = clamp_dim(csr_wr_data, MAX_WIDTH);
               cfg_hit = 1'b1;
            end
            CSR_IMAGE_HEIGHT: begin
               hgt_in  = clamp_dim(csr_wr_data, MAX_HEIGHT);
               cfg_hit = 1'b1;
            end
            default: begin
               cfg_hit = 1'b0;
            end
         endcase
      end
      if (cfg_hit) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (emit && last) begin
            col_in = '0;
            row_in = '0;
         end else if (col_wrap) begin
            col_in = '0;
            row_in = row_ff + ROW_BITS'(1);
         end else begin
            col_in = col_ff + COL_BITS'(1);
         end
      end
   end

   // second step: line store data, window shift, masked push
   always_comb begin
      pair    = fwd_hit_ff ? fwd_data_ff : rd_ff;
      wr_pair = {pair[PIXEL_BITS-1:0], s1_pix_ff};
      for (int r = 0; r < WIN_SIDE; r++) begin
         win_in[r*WIN_SIDE]     = win_ff[r*WIN_SIDE + 1];
         win_in[r*WIN_SIDE + 1] = win_ff[r*WIN_SIDE + 2];
      end
      win_in[2] = pair[2*PIXEL_BITS-1:PIXEL_BITS];
      win_in[5] = pair[PIXEL_BITS-1:0];
      win_in[8] = s1_pix_ff;
      if (!s1_valid_ff) begin
         for (int k = 0; k < WIN_CELLS; k++) begin
            win_in[k] = win_ff[k];
         end
      end
      for (int k = 0; k < WIN_CELLS; k++) begin
         logic keep;
         keep = 1'b1;
         if ((k / WIN_SIDE == 0) && !s1_mask_ff.up_ok)    keep = 1'b0;
         if ((k / WIN_SIDE == 2) && !s1_mask_ff.dn_ok)    keep = 1'b0;
         if ((k % WIN_SIDE == 0) && !s1_mask_ff.left_ok)  keep = 1'b0;
         if ((k % WIN_SIDE == 2) && !s1_mask_ff.right_ok) keep = 1'b0;
         push_data.cells[k] = keep ? win_in[k] : '0;
      end
      push_data.last = s1_last_ff;
      push_valid     = s1_valid_ff && s1_emit_ff;
   end

   always_comb begin
      s1_valid_in = accept;
      s1_emit_in  = emit;
      s1_last_in  = last;
      s1_pix_in   = pix_v;
      s1_col_in   = col_ff;
      s1_mask_in  = mask;
      fwd_hit_in  = s1_valid_ff && (s1_col_ff == col_ff);
      fwd_data_in = wr_pair;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wid_ff      <= clamp_dim(CFG_BITS'(WIDTH_RESET), MAX_WIDTH);
         hgt_ff      <= clamp_dim(CFG_BITS'(HEIGHT_RESET), MAX_HEIGHT);
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         wid_ff      <= wid_in;
         hgt_ff      <= hgt_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_emit_ff  <= s1_emit_in;
         s1_last_ff  <= s1_last_in;
         s1_pix_ff   <= s1_pix_in;
         s1_col_ff   <= s1_col_in;
         s1_mask_ff  <= s1_mask_in;
         fwd_hit_ff  <= fwd_hit_in;
         fwd_data_ff <= fwd_data_in;
      end
      for (int k = 0; k < WIN_CELLS; k++) begin
         win_ff[k] <= win_in[k];
      end
   end

   // line store port: read for the accepted tick, write back in the next cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= line_mem_ff[col_ff];
      end
      if (s1_valid_ff) begin
         line_mem_ff[s1_col_ff] <= wr_pair;
      end
   end

endmodule

// File: sv/atm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atm_queue
// short register queue of masked windows between front and back
// ----------------------------------------------------------------------------
module atm_queue import atm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   input  atm_win_type   push_data,
   input  logic          pop,
   output atm_win_type   head_data,
   output atm_qstat_type qstat
);

   atm_win_type          entries_ff [QDEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] level_ff, level_in;
   logic                 do_pop;

   assign qstat.level      = level_ff;
   assign qstat.head_valid = level_ff != '0;
   assign head_data        = entries_ff[rd_ptr_ff];
   assign do_pop           = pop && qstat.head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QDEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QDEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_BITS'(1);
      end
      if (push_valid && !do_pop) begin
         level_in = level_ff + QCNT_BITS'(1);
      end else if (!push_valid && do_pop) begin
         level_in = level_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: sv/atm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atm_back
// trimmed sum, rounding divide by seven and the result register
// ----------------------------------------------------------------------------
module atm_back import atm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  atm_win_type   head_data,
   input  atm_qstat_type qstat,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output atm_rsp_type   rsp_data
);

   logic                 b_valid_ff, b_valid_in;
   logic                 c_valid_ff, c_valid_in;
   logic [SUM_BITS-1:0]  sum_ff, sum_in;
   atm_pix_type          min_ff, min_in;
   atm_pix_type          max_ff, max_in;
   logic                 b_last_ff, b_last_in;
   logic [PROD_BITS-1:0] prod_ff, prod_in;
   logic                 c_last_ff, c_last_in;
   logic                 ready_b, ready_c;
   logic [SUM_BITS-1:0]  trimmed;

   assign ready_c = !c_valid_ff || !rsp_stall;
   assign ready_b = !b_valid_ff || ready_c;
   assign pop     = qstat.head_valid && ready_b;

   // sum, minimum and maximum of the nine cells
   always_comb begin
      sum_in = '0;
      min_in = head_data.cells[0];
      max_in = head_data.cells[0];
      for (int k = 0; k < WIN_CELLS; k++) begin
         sum_in = sum_in + SUM_BITS'(head_data.cells[k]);
         if (head_data.cells[k] < min_in) min_in = head_data.cells[k];
         if (head_data.cells[k] > max_in) max_in = head_data.cells[k];
      end
      b_last_in  = head_data.last;
      b_valid_in = ready_b ? qstat.head_valid : b_valid_ff;
   end

   // drop the extremes, add the rounding bias, multiply by the reciprocal of seven
   always_comb begin
      trimmed    = sum_ff - SUM_BITS'(min_ff) - SUM_BITS'(max_ff) + SUM_BITS'(ROUND_BIAS);
      prod_in    = PROD_BITS'(trimmed) * PROD_BITS'(RECIP);
      c_last_in  = b_last_ff;
      c_valid_in = ready_c ? b_valid_ff : c_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_b) begin
         sum_ff    <= sum_in;
         min_ff    <= min_in;
         max_ff    <= max_in;
         b_last_ff <= b_last_in;
      end
      if (ready_c) begin
         prod_ff   <= prod_in;
         c_last_ff <= c_last_in;
      end
   end

   assign rsp_valid          = c_valid_ff;
   assign rsp_data.filtered  = prod_ff[DIV_SHIFT +: PIXEL_BITS];
   assign rsp_data.frame_end = c_last_ff;

endmodule

// File: sv/alpha_trimmed_mean_3x3.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpha_trimmed_mean_3x3
// streaming 3x3 alpha-trimmed mean filter, extremes dropped, seven averaged
// ----------------------------------------------------------------------------
// channel  dir  handshake              payload
// req_     in   req_valid, req_stall   atm_req_type: pixel, padding
// rsp_     out  rsp_valid, rsp_stall   atm_rsp_type: filtered, frame_end
// csr_     in   csr_wr_en              csr_index, csr_wr_data
//
// one request per clock unless stalled; w x h frames take w*h + w + 1 requests
// the request that completes a window goes on to a result through these steps:
//    line store read, window and mask, queue, sum/min/max, reciprocal multiply
// reset clears position, queue and pipeline valids and sets both sizes to 1024;
//    line stores are not swept, cells outside the image are always masked
// req_stall rises only once stalled windows and a push fill the 4-entry queue
// ----------------------------------------------------------------------------
module alpha_trimmed_mean_3x3 import atm_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  atm_req_type             req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output atm_rsp_type             rsp_data,
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]     csr_wr_data
);

   // front to queue
   logic          push_valid;
   atm_win_type   push_data;

   // queue to back
   atm_win_type   head_data;
   atm_qstat_type qstat;
   logic          pop;

   // position tracking, line stores, window, edge masks
   atm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .qstat       (qstat),
      .push_valid  (push_valid),
      .push_data   (push_data)
   );

   // decouples the window stage from result back-pressure
   atm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .head_data  (head_data),
      .qstat      (qstat)
   );

   // trimmed mean arithmetic and result register
   atm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_data (head_data),
      .qstat     (qstat),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: sv/atm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atm_checker
// port-level checks on the filter, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module atm_checker import atm_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input atm_rsp_type rsp_data
);

   // nothing pending and request side open straight after reset
   `ATM_ASSERT_ALWAYS(a_reset_clean, clock, (reset |=> (!rsp_valid && !req_stall)), "not clean after reset")

   // a waiting result holds until taken
   `ATM_ASSERT(a_rsp_hold, clock, reset, ((rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data))), "result changed while stalled")

   // the request side reopens after any cycle without result back-pressure
   `ATM_ASSERT(a_req_reopen, clock, reset, (!rsp_stall |=> !req_stall), "request stalled without result back-pressure")

   // a request offered with no back-pressure anywhere is taken
   `ATM_ASSERT(a_req_flow, clock, reset, ((req_valid && !rsp_stall) |=> !(req_valid && req_stall && !$past(req_stall) && !$past(rsp_stall)) || !req_stall), "request refused")

endmodule

bind alpha_trimmed_mean_3x3 atm_checker u_atm_checker (.*);

// File: test/alpha_trimmed_mean_3x3_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpha_trimmed_mean_3x3_tb
// self-checking bench of the streaming 3x3 alpha-trimmed mean filter
// ----------------------------------------------------------------------------
// pixel frames in raster order go in over the request channel, each frame
// followed by its width+1 flush ticks. a behavioural copy of the filter, with
// its own line stores, window and raster position, works out every filtered
// pixel as the request is taken and queues it. the result monitor compares
// each filtered pixel and frame_end flag with the oldest queued one. the run
// covers reset sizes, hand-built corner frames, spare register indexes, a
// restart part way through a frame, the size extremes, a long receiver
// hold-off and three stretches of random frames under changing idle patterns
// ----------------------------------------------------------------------------
module alpha_trimmed_mean_3x3_tb;
   import atm_pkg::*;

   // no request or result for this many cycles means the block has hung
   localparam int IDLE_LIMIT    = 4000;
   // cycles left for a request still in the pipe that will cause no result
   localparam int SETTLE_CYCLES = 8;
   localparam int REPORT_CAP    = 64;
   localparam int STAGE_ITEMS   = 300;
   localparam int HOLD_OFF      = 60;
   // ticks sent into frames too large to finish
   localparam int RESET_TICKS   = 24;
   localparam int CLAMP_TICKS   = 20;

   // register indexes the block decodes to nothing
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_LOW  = CSR_IDX_BITS'(2);
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_HIGH = CSR_IDX_BITS'(3);

   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    req_valid   = 1'b0;
   logic                    req_stall;
   atm_req_type             req_data    = '0;
   logic                    rsp_valid;
   logic                    rsp_stall   = 1'b0;
   atm_rsp_type             rsp_data;
   logic                    csr_wr_en   = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index   = '0;
   logic [CFG_BITS-1:0]     csr_wr_data = '0;

   // idle pattern of both sides, in percent of cycles
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_off_left = 0;

   int requests_sent   = 0;
   int results_checked = 0;
   int frames_ended    = 0;
   int mismatch_count  = 0;
   int quiet_cycles    = 0;

   // filter model state: two rows above the incoming one, window, position
   atm_pix_type         older_row [MAX_WIDTH];
   atm_pix_type         newer_row [MAX_WIDTH];
   atm_pix_type         win_cell  [WIN_CELLS];
   int unsigned         next_col;
   int unsigned         next_row;
   logic [CFG_BITS-1:0] cfg_width;
   logic [CFG_BITS-1:0] cfg_height;

   atm_rsp_type expected_pixels [$];

   alpha_trimmed_mean_3x3 dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // filter model
   // ---------------------------------------------------------------------------

   // zero means one, anything past the store size means the store size
   function automatic int unsigned effective_size(input logic [CFG_BITS-1:0] raw,
                                                  input int unsigned limit);
      if (raw == '0) begin
         return 1;
      end
      return (int'(raw) > limit) ? limit : int'(raw);
   endfunction

   function automatic void clear_model();
      foreach (older_row[i]) begin
         older_row[i] = '0;
         newer_row[i] = '0;
      end
      foreach (win_cell[i]) begin
         win_cell[i] = '0;
      end
      next_col   = 0;
      next_row   = 0;
      cfg_width  = CFG_BITS'(WIDTH_RESET);
      cfg_height = CFG_BITS'(HEIGHT_RESET);
   endfunction

   // a write to either size restarts the raster; spare indexes change nothing
   function automatic void note_register_write(input logic [CSR_IDX_BITS-1:0] index,
                                               input logic [CFG_BITS-1:0] value);
      case (index)
         CSR_IMAGE_WIDTH: begin
            cfg_width = value;
            next_col  = 0;
            next_row  = 0;
         end
         CSR_IMAGE_HEIGHT: begin
            cfg_height = value;
            next_col   = 0;
            next_row   = 0;
         end
         default: begin
         end
      endcase
   endfunction

   // one request in, at most one filtered pixel queued
   function automatic void filter_pixel(input atm_req_type item);
      int unsigned w, h, ic, ir, total, lowest, highest, tap;
      int          centre_row, centre_col, rr, cx;
      atm_pix_type incoming;
      atm_rsp_type outcome;
      w  = effective_size(cfg_width, MAX_WIDTH);
      h  = effective_size(cfg_height, MAX_HEIGHT);
      ic = (next_col >= w) ? 0 : next_col;
      ir = next_row;

      // padding, and anything arriving during the flush, counts as zero
      incoming = (item.padding || ir >= h) ? '0 : item.pixel;

      for (int r = 0; r < WIN_SIDE; r++) begin
         win_cell[r*WIN_SIDE]     = win_cell[r*WIN_SIDE + 1];
         win_cell[r*WIN_SIDE + 1] = win_cell[r*WIN_SIDE + 2];
      end
      win_cell[2]   = older_row[ic];
      win_cell[5]   = newer_row[ic];
      win_cell[8]   = incoming;
      older_row[ic] = newer_row[ic];
      newer_row[ic] = incoming;

      // centre is a row up and a column left, or two rows up in the last column
      if (ic >= 1) begin
         centre_row = int'(ir) - 1;
         centre_col = int'(ic) - 1;
      end else begin
         centre_row = int'(ir) - 2;
         centre_col = int'(w) - 1;
      end

      ic++;
      if (ic >= w) begin
         ic = 0;
         ir++;
      end
      next_col = ic;
      next_row = ir;

      if (centre_row < 0 || centre_row >= int'(h)) begin
         return;
      end

      total   = 0;
      lowest  = '1;
      highest = 0;
      for (int k = 0; k < WIN_CELLS; k++) begin
         rr = centre_row + k / WIN_SIDE - 1;
         cx = centre_col + k % WIN_SIDE - 1;
         if (rr < 0 || rr >= int'(h) || cx < 0 || cx >= int'(w)) begin
            tap = 0;
         end else begin
            tap = win_cell[k];
         end
         total += tap;
         if (tap < lowest) begin
            lowest = tap;
         end
         if (tap > highest) begin
            highest = tap;
         end
      end

      // drop both extremes, round the mean of the rest to nearest
      total = total - lowest - highest;
      outcome.filtered  = atm_pix_type'((total + KEEP_COUNT / 2) / KEEP_COUNT);
      outcome.frame_end = (centre_row == int'(h) - 1) && (centre_col == int'(w) - 1);
      if (outcome.frame_end) begin
         next_col = 0;
         next_row = 0;
      end
      expected_pixels.insert(expected_pixels.size(), outcome);
   endfunction

   // ---------------------------------------------------------------------------
   // receiver, result monitor and watchdog
   // ---------------------------------------------------------------------------

   // a pending hold-off keeps the result side stalled for that many cycles
   always @(posedge clock) begin
      if (hold_off_left > 0) begin
         rsp_stall <= 1'b1;
         hold_off_left = hold_off_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   function automatic void report_mismatch(input string field, input int want, input int got);
      mismatch_count++;
      if (mismatch_count <= REPORT_CAP) begin
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      end
   endfunction

   always @(posedge clock) begin
      atm_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            report_mismatch("unexpected result, filtered", -1, rsp_data.filtered);
         end else begin
            want = expected_pixels.pop_front();
            results_checked++;
            if (rsp_data.frame_end) begin
               frames_ended++;
            end
            if (rsp_data.filtered !== want.filtered) begin
               report_mismatch("filtered", want.filtered, rsp_data.filtered);
            end
            if (rsp_data.frame_end !== want.frame_end) begin
               report_mismatch("frame_end", want.frame_end, rsp_data.frame_end);
            end
         end
      end
   end

   // counts cycles in which neither channel moves anything
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t ns: nothing moved for %0d cycles, %0d results outstanding",
                     $time, IDLE_LIMIT, expected_pixels.size());
            $display("alpha_trimmed_mean_3x3 test failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // stimulus helpers, all entered and left just after a rising edge
   // ---------------------------------------------------------------------------

   // extremes show up often so that min and max trimming gets exercised
   function automatic atm_pix_type random_pixel();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return atm_pix_type'($urandom);
      endcase
   endfunction

   task automatic send_request(input atm_pix_type pixel, input logic padding);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_data.pixel   <= pixel;
      req_data.padding <= padding;
      do begin
         @(posedge clock);
      end while (req_stall);
      requests_sent++;
      filter_pixel('{pixel: pixel, padding: padding});
   endtask

   // wait for every queued result, then for requests that cause none
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_BITS-1:0] index,
                                 input logic [CFG_BITS-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= value;
      @(posedge clock);
      note_register_write(index, value);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_frame_size(input logic [CFG_BITS-1:0] width_raw,
                                 input logic [CFG_BITS-1:0] height_raw);
      settle();
      write_register(CSR_IMAGE_WIDTH, width_raw);
      write_register(CSR_IMAGE_HEIGHT, height_raw);
   endtask

   // full frame plus its flush; pad_pct puts zero ticks inside the frame,
   // stray_pct puts real pixels into the flush where they must be ignored
   task automatic send_frame(input int w, input int h, input int pad_pct, input int stray_pct);
      for (int i = 0; i < w * h; i++) begin
         send_request(random_pixel(), $urandom_range(99) < pad_pct);
      end
      for (int i = 0; i <= w; i++) begin
         send_request(random_pixel(), !($urandom_range(99) < stray_pct));
      end
   endtask

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   // sizes out of reset are 1024 x 1024, so a short run of ticks gives
   // nothing at all; the frame is left unfinished
   task automatic test_reset_sizes();
      for (int i = 0; i < RESET_TICKS; i++) begin
         send_request(random_pixel(), 1'b0);
      end
      settle();
   endtask

   // hand-built 3x3 frame with extremes, a padding tick inside the frame and
   // a stray pixel in the flush, then a 2x2 frame straight after frame_end
   task automatic test_corner_frames();
      atm_pix_type grid [9];
      grid = '{8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd128, 8'd1, 8'd254};
      set_frame_size(CFG_BITS'(3), CFG_BITS'(3));
      for (int i = 0; i < 9; i++) begin
         // centre pixel goes in as padding, so 255 must read as zero
         send_request(grid[i], i == 4);
      end
      send_request(8'd0, 1'b1);
      send_request(8'd170, 1'b0);
      send_request(8'd255, 1'b1);
      send_request(8'd0, 1'b1);
      set_frame_size(CFG_BITS'(2), CFG_BITS'(2));
      repeat (4) send_request(8'd255, 1'b0);
      repeat (3) send_request(8'd255, 1'b1);
      settle();
   endtask

   // writes to the spare indexes in the middle of a frame must not restart it
   task automatic test_spare_registers();
      set_frame_size(CFG_BITS'(4), CFG_BITS'(3));
      for (int i = 0; i < 6; i++) begin
         send_request(random_pixel(), 1'b0);
      end
      settle();
      write_register(CSR_SPARE_LOW, CFG_BITS'($urandom));
      write_register(CSR_SPARE_HIGH, '1);
      for (int i = 6; i < 12; i++) begin
         send_request(random_pixel(), 1'b0);
      end
      for (int i = 0; i < 5; i++) begin
         send_request(random_pixel(), 1'b1);
      end
      settle();
   endtask

   // abandon a frame part way, restart it with the same size; stale line store
   // contents must stay masked out of the next frame
   task automatic test_restart_mid_frame();
      set_frame_size(CFG_BITS'(5), CFG_BITS'(4));
      for (int i = 0; i < 9; i++) begin
         send_request(8'd255, 1'b0);
      end
      set_frame_size(CFG_BITS'(5), CFG_BITS'(4));
      send_frame(5, 4, 0, 0);
      settle();
   endtask

   // zero and all-ones register values, single pixel, single row and column;
   // all-ones sizes clamp to the store size, so those frames stay unfinished:
   // a clamped width gives no early result, a clamped height no early frame_end
   task automatic test_size_extremes();
      set_frame_size('0, '0);
      send_frame(1, 1, 0, 50);
      set_frame_size('1, CFG_BITS'(2));
      repeat (CLAMP_TICKS) send_request(random_pixel(), 1'b0);
      set_frame_size(CFG_BITS'(1), '1);
      repeat (CLAMP_TICKS) send_request(random_pixel(), 1'b0);
      set_frame_size(CFG_BITS'(2), CFG_BITS'(1));
      send_frame(2, 1, 0, 0);
      set_frame_size(CFG_BITS'(1), CFG_BITS'(2));
      send_frame(1, 2, 0, 0);
      settle();
   endtask

   // receiver stops for a long stretch while requests keep coming, so the
   // output queue fills and the block has to stall its input
   task automatic test_back_pressure();
      set_frame_size(CFG_BITS'(8), CFG_BITS'(6));
      hold_off_left = HOLD_OFF;
      send_frame(8, 6, 5, 20);
      settle();
   endtask

   // mostly whole frames of random size and content, some runs of loose ticks
   // that put the raster out of step until the next size write
   task automatic test_random_traffic(input int send_pct, input int recv_pct);
      int                  sent_at_start, w, h;
      logic [CFG_BITS-1:0] width_raw, height_raw;
      bit                  out_of_step;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      sent_at_start = requests_sent;
      out_of_step   = 1'b1;
      w = 1;
      h = 1;
      while (requests_sent - sent_at_start < STAGE_ITEMS) begin
         if ($urandom_range(99) < 12) begin
            repeat ($urandom_range(1, 15)) send_request(random_pixel(), 1'($urandom_range(1)));
            out_of_step = 1'b1;
         end else begin
            if (out_of_step || $urandom_range(99) < 30) begin
               case ($urandom_range(19))
                  0: width_raw = '0;
                  1: width_raw = CFG_BITS'($urandom_range(11, 48));
                  default: width_raw = CFG_BITS'($urandom_range(1, 10));
               endcase
               height_raw = ($urandom_range(9) == 0) ? '0 : CFG_BITS'($urandom_range(1, 8));
               w = effective_size(width_raw, MAX_WIDTH);
               h = effective_size(height_raw, MAX_HEIGHT);
               set_frame_size(width_raw, height_raw);
               out_of_step = 1'b0;
            end
            send_frame(w, h, 4, 20);
         end
      end
      settle();
   endtask

   initial begin
      clear_model();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 26;
      recv_idle_pct = 86;
      test_reset_sizes();
      test_corner_frames();
      test_spare_registers();
      test_restart_mid_frame();
      test_size_extremes();
      test_back_pressure();

      test_random_traffic(26, 86);
      test_random_traffic(86, 26);
      test_random_traffic(0, 0);

      settle();
      $display("%0d requests sent, %0d filtered pixels checked over %0d whole frames",
               requests_sent, results_checked, frames_ended);
      $display("sizes 1 to 1024 incl. clamped values, padding, stray flush pixels, hold-off");
      if (mismatch_count == 0) begin
         $display("alpha_trimmed_mean_3x3 test passed");
      end else begin
         $display("alpha_trimmed_mean_3x3 test failed");
      end
      $finish;
   end

endmodule
